// ===== design/e2c_pkg.sv =====
// Shared types and constants for the epoch to calendar converter.
// Used by e2c_front, e2c_queue, e2c_back and the top level.
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int EPOCH_W = 32;
    localparam int TZ_W    = 5;

    localparam logic signed [TZ_W-1:0] TZ_RESET      = 5'b11010;
    localparam logic signed [33:0]     SECS_PER_HOUR = 34'sd3600;
    localparam logic signed [33:0]     LIMIT_SECS    = 34'sd4102444800;

    // reciprocals for division by constants: x / c == (x * M) >> K over the used range
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // (s >> 7) / 675, K = 35
    localparam logic [15:0] QUAD_RECIP = 16'd45934;     // d / 1461,       K = 26
    localparam logic [16:0] WEEK_RECIP = 17'd74899;     // d / 7,          K = 19
    localparam logic [12:0] HOUR_RECIP = 13'd4661;      // (s >> 4) / 225, K = 20
    localparam logic [15:0] MIN_RECIP  = 16'd34953;     // (s >> 2) / 15,  K = 19

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] DAYS_PER_QUAD = 17'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [11:0] YEAR_BEFORE   = 12'd1969;

    typedef struct packed {
        logic [EPOCH_W-1:0] secs;
        logic               oor;
    } e2c_item_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday;
        logic        oor;
    } e2c_result_t;

    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== design/e2c_front.sv =====
// Front end: holds the timezone register, accepts input beats, applies the offset
// and flags times outside 1970..2099. Depends on e2c_pkg.
`timescale 1ns / 1ps

module e2c_front
    import e2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [EPOCH_W-1:0] s_axis_tdata,
    output logic               push_valid,
    input  logic               push_ready,
    output e2c_item_t          push_item
);

    logic signed [TZ_W-1:0] tz_reg;
    logic                   valid_reg;
    logic                   valid_next;
    e2c_item_t              item_reg;
    e2c_item_t              item_next;
    logic signed [33:0]     tz_ext;
    logic signed [33:0]     shifted;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !valid_reg || push_ready;
    assign push_valid    = valid_reg;
    assign push_item     = item_reg;

    assign tz_ext  = 34'(tz_reg);
    assign shifted = $signed({2'b00, s_axis_tdata}) + 34'(tz_ext * SECS_PER_HOUR);

    always_comb
    begin
        item_next.secs = shifted[EPOCH_W-1:0];
        item_next.oor  = shifted[33] || (shifted >= LIMIT_SECS);
        valid_next     = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg    <= TZ_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tz_reg <= cfg_data[TZ_W-1:0];
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/e2c_queue.sv =====
// Short flop queue between the front end and the conversion pipeline.
// Depends on e2c_pkg for the item type.
`timescale 1ns / 1ps

module e2c_queue
    import e2c_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  e2c_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output e2c_item_t pop_item
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    e2c_item_t       slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== design/e2c_back.sv =====
// Conversion pipeline: five stages from shifted seconds to calendar fields,
// last stage is the output register. Depends on e2c_pkg.
`timescale 1ns / 1ps

module e2c_back
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  e2c_item_t   pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output e2c_result_t out_result
);

    logic        en;
    logic [4:0]  valid_reg;
    logic [4:0]  valid_next;

    logic [31:0] s1_secs_reg;
    logic        s1_oor_reg;
    logic [15:0] s1_days_reg;
    logic [50:0] s1_prod;

    logic [16:0] s2_sod_reg;
    logic        s2_oor_reg;
    logic [16:0] s2_d1_reg;
    logic [6:0]  s2_quad_reg;
    logic [16:0] s2_wx_reg;
    logic [14:0] s2_wq_reg;
    logic [16:0] s2_d1;
    logic [16:0] s2_wx;
    logic [32:0] s2_qprod;
    logic [33:0] s2_wprod;
    logic [31:0] s2_sod_full;

    logic [16:0] s3_sod_reg;
    logic        s3_oor_reg;
    logic [6:0]  s3_quad_reg;
    logic [10:0] s3_rem_reg;
    logic [2:0]  s3_wday_reg;
    logic [4:0]  s3_hour_reg;
    logic [10:0] s3_mins_reg;
    logic [16:0] s3_rem_full;
    logic [16:0] s3_wday_full;
    logic [25:0] s3_hprod;
    logic [30:0] s3_mprod;

    logic        s4_oor_reg;
    logic [5:0]  s4_sec_reg;
    logic [5:0]  s4_min_reg;
    logic [4:0]  s4_hour_reg;
    logic [8:0]  s4_yday_reg;
    logic [11:0] s4_year_reg;
    logic        s4_leap_reg;
    logic [2:0]  s4_wday_reg;
    logic [1:0]  s4_yin;
    logic [16:0] s4_sec_full;
    logic [10:0] s4_min_full;

    e2c_result_t out_reg;
    e2c_result_t out_next;
    logic [3:0]  s5_mon;
    logic [8:0]  s5_mday;

    assign en         = !valid_reg[4] || out_ready;
    assign pop_ready  = en;
    assign out_valid  = valid_reg[4];
    assign out_result = out_reg;

    assign valid_next = en ? {valid_reg[3:0], pop_valid} : valid_reg;

    assign s1_prod = 51'(pop_item.secs[31:7]) * 51'(DAY_RECIP);

    assign s2_sod_full = s1_secs_reg - 32'(s1_days_reg) * SECS_PER_DAY;
    assign s2_d1       = 17'(s1_days_reg) + 17'(DAYS_PER_YEAR);
    assign s2_wx       = 17'(s1_days_reg) + 17'd4;
    assign s2_qprod    = 33'(s2_d1) * 33'(QUAD_RECIP);
    assign s2_wprod    = 34'(s2_wx) * 34'(WEEK_RECIP);

    assign s3_rem_full  = s2_d1_reg - 17'(s2_quad_reg) * DAYS_PER_QUAD;
    assign s3_wday_full = s2_wx_reg - 17'(s2_wq_reg) * 17'd7;
    assign s3_hprod     = 26'(s2_sod_reg[16:4]) * 26'(HOUR_RECIP);
    assign s3_mprod     = 31'(s2_sod_reg[16:2]) * 31'(MIN_RECIP);

    assign s4_sec_full = s3_sod_reg - 17'(s3_mins_reg) * 17'd60;
    assign s4_min_full = s3_mins_reg - 11'(s3_hour_reg) * 11'd60;

    always_comb
    begin
        if (s3_rem_reg >= 11'd1095)
        begin
            s4_yin = 2'd3;
        end
        else if (s3_rem_reg >= 11'd730)
        begin
            s4_yin = 2'd2;
        end
        else if (s3_rem_reg >= 11'd365)
        begin
            s4_yin = 2'd1;
        end
        else
        begin
            s4_yin = 2'd0;
        end
    end

    always_comb
    begin
        s5_mon = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (s4_yday_reg >= month_start(4'(k), s4_leap_reg))
            begin
                s5_mon = 4'(k);
            end
        end
        s5_mday = s4_yday_reg - month_start(s5_mon, s4_leap_reg);

        out_next = '0;
        out_next.oor = s4_oor_reg;
        if (!s4_oor_reg)
        begin
            out_next.second       = s4_sec_reg;
            out_next.minute       = s4_min_reg;
            out_next.hour         = s4_hour_reg;
            out_next.day_of_month = s5_mday[4:0] + 5'd1;
            out_next.month        = s5_mon;
            out_next.year         = s4_year_reg;
            out_next.day_of_year  = s4_yday_reg;
            out_next.weekday      = s4_wday_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_secs_reg <= pop_item.secs;
            s1_oor_reg  <= pop_item.oor;
            s1_days_reg <= s1_prod[50:35];

            s2_sod_reg  <= s2_sod_full[16:0];
            s2_oor_reg  <= s1_oor_reg;
            s2_d1_reg   <= s2_d1;
            s2_quad_reg <= s2_qprod[32:26];
            s2_wx_reg   <= s2_wx;
            s2_wq_reg   <= s2_wprod[33:19];

            s3_sod_reg  <= s2_sod_reg;
            s3_oor_reg  <= s2_oor_reg;
            s3_quad_reg <= s2_quad_reg;
            s3_rem_reg  <= s3_rem_full[10:0];
            s3_wday_reg <= s3_wday_full[2:0];
            s3_hour_reg <= s3_hprod[24:20];
            s3_mins_reg <= s3_mprod[29:19];

            s4_oor_reg  <= s3_oor_reg;
            s4_sec_reg  <= s4_sec_full[5:0];
            s4_min_reg  <= s4_min_full[5:0];
            s4_hour_reg <= s3_hour_reg;
            s4_yday_reg <= 9'(s3_rem_reg - 11'(s4_yin) * 11'(DAYS_PER_YEAR));
            s4_year_reg <= YEAR_BEFORE + {3'b000, s3_quad_reg, 2'b00} + 12'(s4_yin);
            s4_leap_reg <= (s4_yin == 2'd3);
            s4_wday_reg <= s3_wday_reg;

            out_reg     <= out_next;
        end
    end

    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && !out_reg.oor) |->
            (out_reg.hour < 5'd24) && (out_reg.minute < 6'd60) && (out_reg.second < 6'd60))
        else $error("time of day field out of range");

    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && !out_reg.oor) |->
            (out_reg.day_of_month != 5'd0) && (out_reg.month <= 4'd11)
            && (out_reg.year >= 12'd1970) && (out_reg.year <= 12'd2099)
            && (out_reg.weekday <= 3'd6))
        else $error("date field out of range");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && out_reg.oor) |->
            (out_reg.year == 12'd0) && (out_reg.day_of_month == 5'd0)
            && (out_reg.day_of_year == 9'd0) && (out_reg.weekday == 3'd0))
        else $error("out of range beat carries nonzero fields");

endmodule

// ===== design/epoch_to_calendar_fields_top.sv =====
// Top level of the epoch to calendar converter: front end, queue, conversion pipeline.
// Depends on e2c_pkg, e2c_front, e2c_queue and e2c_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_data[4:0] timezone_hours (signed)
//  s_axis   | in        | tvalid / tready        | tdata[31:0] epoch_seconds
//  m_axis   | out       | tvalid / tready        | tdata calendar fields, tuser out_of_range
//
// One beat per cycle sustained while m_axis_tready stays high; a beat passes the front register,
// which loads at the beat, then the queue and five pipeline stages, the last of them the
// output register.
// Reset sets the timezone to -6 hours and empties the queue and pipeline.
// A stalled output freezes the pipeline; the queue then fills up to QUEUE_DEPTH beats and the
// front register holds one more before s_axis_tready drops. cfg_ready is always high.
`timescale 1ns / 1ps

module epoch_to_calendar_fields_top
    import e2c_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,        // [4:0] timezone_hours
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
    // [25:22] month, [37:26] year, [46:38] day_of_year, [49:47] weekday
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser     // [0] out_of_range
);

    logic        push_valid;
    logic        push_ready;
    e2c_item_t   push_item;
    logic        pop_valid;
    logic        pop_ready;
    e2c_item_t   pop_item;
    e2c_result_t result;

    e2c_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    e2c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    e2c_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {6'b000000, result.weekday, result.day_of_year, result.year,
                           result.month, result.day_of_month, result.hour,
                           result.minute, result.second};
    assign m_axis_tuser = result.oor;

endmodule
